// ===== rtl/ltcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltcd_pkg
// shared constants, codes and types of the tile cache directory
// ----------------------------------------------------------------------------
package ltcd_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int TILE_SIDE_DEFAULT = 256;

   localparam int TILE_W   = 24;
   localparam int PIX_W    = 16;
   localparam int STAMP_W  = 64;
   localparam int CSR_AW   = 3;

   // operation codes
   localparam logic [2:0] OP_COLOUR = 3'd0;
   localparam logic [2:0] OP_LIGHT  = 3'd1;
   localparam logic [2:0] OP_FILL   = 3'd2;
   localparam logic [2:0] OP_CHECK  = 3'd3;
   localparam logic [2:0] OP_INVAL  = 3'd4;

   // result status codes
   localparam logic [2:0] ST_DISABLED   = 3'd0;
   localparam logic [2:0] ST_HIT        = 3'd1;
   localparam logic [2:0] ST_HIT_ABSENT = 3'd2;
   localparam logic [2:0] ST_MISS       = 3'd3;
   localparam logic [2:0] ST_DONE       = 3'd4;
   localparam logic [2:0] ST_DROPPED    = 3'd5;

   // register index (paddr bit 2)
   localparam logic REG_ENABLED = 1'b0;

   typedef struct packed {
      logic signed [TILE_W-1:0] tile_x;
      logic signed [TILE_W-1:0] tile_z;
      logic [PIX_W-1:0]         pixel_index;
   } tile_info_type;

   typedef struct packed {
      logic signed [TILE_W-1:0] tile_x;
      logic signed [TILE_W-1:0] tile_z;
      logic [7:0]               dimension;
      logic [31:0]              file_time;
   } tag_type;

   typedef struct packed {
      logic [2:0]               status;
      logic [3:0]               slot_out;
      logic signed [TILE_W-1:0] tile_x;
      logic signed [TILE_W-1:0] tile_z;
      logic [PIX_W-1:0]         pixel_index;
   } result_type;

endpackage

// ===== rtl/ltcd_channels.sv =====
// ----------------------------------------------------------------------------
// ltcd channels
// valid/ready request and response channels of the tile cache directory
// ----------------------------------------------------------------------------
interface ltcd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic signed [31:0] world_x;
   logic signed [31:0] world_z;
   logic [7:0]  dimension;
   logic [3:0]  slot;
   logic        file_present;
   logic [31:0] file_time;

   modport source (output valid, operation, world_x, world_z, dimension, slot,
                   file_present, file_time, input ready);
   modport sink (input valid, operation, world_x, world_z, dimension, slot,
                 file_present, file_time, output ready);
endinterface

interface ltcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  slot_out;
   logic signed [23:0] tile_x;
   logic signed [23:0] tile_z;
   logic [15:0] pixel_index;

   modport source (output valid, status, slot_out, tile_x, tile_z, pixel_index,
                   input ready);
   modport sink (input valid, status, slot_out, tile_x, tile_z, pixel_index,
                 output ready);
endinterface

// ===== rtl/ltcd_tile_calc.sv =====
// ----------------------------------------------------------------------------
// ltcd_tile_calc
// floors world coordinates to a tile and forms the in-tile pixel index
// ----------------------------------------------------------------------------
module ltcd_tile_calc #(
   parameter int TILE_SIDE = ltcd_pkg::TILE_SIDE_DEFAULT
) (
   input  logic signed [31:0]     world_x,
   input  logic signed [31:0]     world_z,
   output ltcd_pkg::tile_info_type tile
);
   localparam int SH = $clog2(TILE_SIDE);
   localparam int PW = (2 * SH > ltcd_pkg::PIX_W) ? 2 * SH : ltcd_pkg::PIX_W;

   logic signed [31:0] qx;
   logic signed [31:0] qz;
   logic [PW-1:0]      pix_wide;

   // arithmetic shift floors toward minus infinity
   assign qx = world_x >>> SH;
   assign qz = world_z >>> SH;
   assign pix_wide = PW'({world_z[SH-1:0], world_x[SH-1:0]});

   assign tile.tile_x      = qx[ltcd_pkg::TILE_W-1:0];
   assign tile.tile_z      = qz[ltcd_pkg::TILE_W-1:0];
   assign tile.pixel_index = pix_wide[ltcd_pkg::PIX_W-1:0];
endmodule

// ===== rtl/ltcd_csr.sv =====
// ----------------------------------------------------------------------------
// ltcd_csr
// apb register holding the enable bit
// ----------------------------------------------------------------------------
module ltcd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ltcd_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic                        enabled
);
   logic enabled_ff;
   logic enabled_in;
   logic sel_enabled;

   assign sel_enabled = (paddr[2] == ltcd_pkg::REG_ENABLED);
   assign pready      = 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      if (psel && penable && pwrite && sel_enabled) begin
         enabled_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   assign prdata  = sel_enabled ? {31'd0, enabled_ff} : 32'd0;
   assign enabled = enabled_ff;
endmodule

// ===== rtl/ltcd_engine.sv =====
// ----------------------------------------------------------------------------
// ltcd_engine
// tag and stamp memories, slot scan, lru victim choice and result register
// ----------------------------------------------------------------------------
module ltcd_engine #(
   parameter int SLOTS = ltcd_pkg::SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enabled,
   input  ltcd_pkg::tile_info_type tile,
   ltcd_req_if.sink                req,
   ltcd_rsp_if.source              rsp
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = SW + 1;
   localparam logic [31:0] SLOTS_U = 32'(SLOTS);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_UPD     = 3'd2;
   localparam logic [2:0] S_SLOTRD  = 3'd3;
   localparam logic [2:0] S_SLOTFIN = 3'd4;
   localparam logic [2:0] S_FIN     = 3'd5;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                found_ff, found_in;
   logic [SLOTS-1:0]    used_ff, used_in;
   logic [SLOTS-1:0]    absent_ff, absent_in;
   logic [SLOTS-1:0]    stamp_v_ff, stamp_v_in;
   logic [63:0]         use_ctr_ff, use_ctr_in;
   logic                recent_valid_ff, recent_valid_in;
   logic [SW-1:0]       recent_slot_ff, recent_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload
   logic [2:0]          op_ff, op_in;
   logic [23:0]         tx_ff, tx_in;
   logic [23:0]         tz_ff, tz_in;
   logic [15:0]         pix_ff, pix_in;
   logic [7:0]          dim_ff, dim_in;
   logic [3:0]          slot_ff, slot_in;
   logic                present_ff, present_in;
   logic [31:0]         ftime_ff, ftime_in;
   logic [SW-1:0]       hit_ff, hit_in;
   logic [SW-1:0]       vic_ff, vic_in;
   logic [63:0]         vic_lu_ff, vic_lu_in;
   ltcd_pkg::result_type pend_ff, pend_in;
   ltcd_pkg::result_type rsp_data_ff, rsp_data_in;

   // memories
   ltcd_pkg::tag_type   tag_mem [SLOTS];
   logic [63:0]         stamp_mem [SLOTS];
   ltcd_pkg::tag_type   tag_rd_ff;
   logic [63:0]         stamp_rd_ff;
   logic [SW-1:0]       rd_addr;
   logic                tag_we;
   logic [SW-1:0]       tag_wa;
   ltcd_pkg::tag_type   tag_wd;
   logic                st_we;
   logic [SW-1:0]       st_wa;
   logic [63:0]         st_wd;

   logic                accept;
   logic                out_free;
   logic                req_slot_ok;
   logic [SW-1:0]       req_sel;
   logic [SW-1:0]       sel;

   assign req.ready   = (state_ff == S_IDLE);
   assign accept      = req.valid && (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign req_slot_ok = ({28'd0, req.slot} < SLOTS_U);
   assign req_sel     = SW'(req.slot);
   assign sel         = SW'(slot_ff);

   always_comb begin
      logic [SW-1:0] e;
      logic [63:0]   lu;
      logic          match;
      logic          colour;
      logic          drop;
      e     = SW'(cnt_ff - CW'(1));
      lu    = stamp_v_ff[e] ? stamp_rd_ff : 64'd0;
      match = used_ff[e] && (tag_rd_ff.tile_x == tx_ff) && (tag_rd_ff.tile_z == tz_ff)
              && (tag_rd_ff.dimension == dim_ff);
      colour = (op_ff == ltcd_pkg::OP_COLOUR);
      drop  = (present_ff && (ftime_ff != tag_rd_ff.file_time))
              || (!present_ff && !absent_ff[sel]) || (present_ff && absent_ff[sel]);

      state_in        = state_ff;
      cnt_in          = cnt_ff;
      found_in        = found_ff;
      used_in         = used_ff;
      absent_in       = absent_ff;
      stamp_v_in      = stamp_v_ff;
      use_ctr_in      = use_ctr_ff;
      recent_valid_in = recent_valid_ff;
      recent_slot_in  = recent_slot_ff;
      rsp_valid_in    = rsp_valid_ff;
      op_in           = op_ff;
      tx_in           = tx_ff;
      tz_in           = tz_ff;
      pix_in          = pix_ff;
      dim_in          = dim_ff;
      slot_in         = slot_ff;
      present_in      = present_ff;
      ftime_in        = ftime_ff;
      hit_in          = hit_ff;
      vic_in          = vic_ff;
      vic_lu_in       = vic_lu_ff;
      pend_in         = pend_ff;
      rsp_data_in     = rsp_data_ff;
      rd_addr         = '0;
      tag_we          = 1'b0;
      tag_wa          = '0;
      tag_wd          = tag_rd_ff;
      st_we           = 1'b0;
      st_wa           = '0;
      st_wd           = use_ctr_ff + 64'd1;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req.operation;
               tx_in      = tile.tile_x;
               tz_in      = tile.tile_z;
               pix_in     = tile.pixel_index;
               dim_in     = req.dimension;
               slot_in    = req.slot;
               present_in = req.file_present;
               ftime_in   = req.file_time;
               pend_in    = '0;
               pend_in.status = ltcd_pkg::ST_DONE;
               state_in   = S_FIN;
               if (req.operation == ltcd_pkg::OP_COLOUR
                   || req.operation == ltcd_pkg::OP_LIGHT) begin
                  if (enabled) begin
                     cnt_in   = '0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end else begin
                     pend_in.status = ltcd_pkg::ST_DISABLED;
                  end
               end else if (req.operation == ltcd_pkg::OP_FILL) begin
                  pend_in.slot_out = req.slot;
                  if (req_slot_ok && used_ff[req_sel]) begin
                     state_in = S_SLOTRD;
                  end
               end else if (req.operation == ltcd_pkg::OP_CHECK) begin
                  pend_in.slot_out = req.slot;
                  if (!enabled) begin
                     pend_in.status = ltcd_pkg::ST_DISABLED;
                  end else if (req_slot_ok && used_ff[req_sel]) begin
                     state_in = S_SLOTRD;
                  end
               end else if (req.operation == ltcd_pkg::OP_INVAL) begin
                  used_in         = '0;
                  absent_in       = '0;
                  stamp_v_in      = '0;
                  use_ctr_in      = 64'd0;
                  recent_valid_in = 1'b0;
                  recent_slot_in  = '0;
               end
            end
         end
         S_SCAN: begin
            // one slot read per cycle, data of slot cnt-1 arrives now
            if (cnt_ff < CW'(SLOTS)) begin
               rd_addr = cnt_ff[SW-1:0];
            end
            if (cnt_ff != '0) begin
               if (match && !found_ff) begin
                  found_in = 1'b1;
                  hit_in   = e;
               end
               if (e == '0 || !used_ff[e] || lu < vic_lu_ff) begin
                  vic_in    = e;
                  vic_lu_in = lu;
               end
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SLOTS)) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            pend_in.tile_x      = tx_ff;
            pend_in.tile_z      = tz_ff;
            pend_in.pixel_index = pix_ff;
            if (found_ff) begin
               pend_in.slot_out = 4'(hit_ff);
               // last-tile fast path leaves the stamps alone
               if (colour && recent_valid_ff && recent_slot_ff == hit_ff
                   && !absent_ff[hit_ff]) begin
                  pend_in.status = ltcd_pkg::ST_HIT;
               end else begin
                  st_we      = 1'b1;
                  st_wa      = hit_ff;
                  stamp_v_in[hit_ff] = 1'b1;
                  use_ctr_in = use_ctr_ff + 64'd1;
                  pend_in.status = absent_ff[hit_ff] ? ltcd_pkg::ST_HIT_ABSENT
                                                     : ltcd_pkg::ST_HIT;
                  if (colour) begin
                     if (absent_ff[hit_ff]) begin
                        recent_valid_in = 1'b0;
                     end else begin
                        recent_valid_in = 1'b1;
                        recent_slot_in  = hit_ff;
                     end
                  end
               end
            end else begin
               tag_we           = 1'b1;
               tag_wa           = vic_ff;
               tag_wd.tile_x    = tx_ff;
               tag_wd.tile_z    = tz_ff;
               tag_wd.dimension = dim_ff;
               tag_wd.file_time = 32'd0;
               st_we            = 1'b1;
               st_wa            = vic_ff;
               stamp_v_in[vic_ff] = 1'b1;
               used_in[vic_ff]    = 1'b1;
               absent_in[vic_ff]  = 1'b1;
               use_ctr_in       = use_ctr_ff + 64'd1;
               pend_in.status   = ltcd_pkg::ST_MISS;
               pend_in.slot_out = 4'(vic_ff);
               if (colour) begin
                  recent_valid_in = 1'b1;
                  recent_slot_in  = vic_ff;
               end
            end
            state_in = S_FIN;
         end
         S_SLOTRD: begin
            rd_addr  = sel;
            state_in = S_SLOTFIN;
         end
         S_SLOTFIN: begin
            if (op_ff == ltcd_pkg::OP_FILL) begin
               tag_we           = 1'b1;
               tag_wa           = sel;
               tag_wd.file_time = present_ff ? ftime_ff : 32'd0;
               absent_in[sel]   = !present_ff;
            end else if (drop) begin
               used_in[sel]   = 1'b0;
               pend_in.status = ltcd_pkg::ST_DROPPED;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cnt_ff          <= '0;
         found_ff        <= 1'b0;
         used_ff         <= '0;
         absent_ff       <= '0;
         stamp_v_ff      <= '0;
         use_ctr_ff      <= 64'd0;
         recent_valid_ff <= 1'b0;
         recent_slot_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         found_ff        <= found_in;
         used_ff         <= used_in;
         absent_ff       <= absent_in;
         stamp_v_ff      <= stamp_v_in;
         use_ctr_ff      <= use_ctr_in;
         recent_valid_ff <= recent_valid_in;
         recent_slot_ff  <= recent_slot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tx_ff       <= tx_in;
      tz_ff       <= tz_in;
      pix_ff      <= pix_in;
      dim_ff      <= dim_in;
      slot_ff     <= slot_in;
      present_ff  <= present_in;
      ftime_ff    <= ftime_in;
      hit_ff      <= hit_in;
      vic_ff      <= vic_in;
      vic_lu_ff   <= vic_lu_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stamp_mem[st_wa] <= st_wd;
      end
      stamp_rd_ff <= stamp_mem[rd_addr];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_data_ff.status;
   assign rsp.slot_out    = rsp_data_ff.slot_out;
   assign rsp.tile_x      = rsp_data_ff.tile_x;
   assign rsp.tile_z      = rsp_data_ff.tile_z;
   assign rsp.pixel_index = rsp_data_ff.pixel_index;
endmodule

// ===== rtl/lru_tile_cache_directory.sv =====
// lookup: the tag memory scan reads one slot per cycle, then the update step runs
// and the result is registered; fill and check: read-modify-write of the slot;
// other items register their result directly; one item in flight, the next is taken
// once its result is registered, while that result may still wait on the output
// reset: synchronous, active high; clearing the valid bits empties the directory
// ----------------------------------------------------------------------------
// lru_tile_cache_directory
// fully associative tile directory with timestamp lru and negative cache
// ----------------------------------------------------------------------------
module lru_tile_cache_directory #(
   parameter int SLOTS     = ltcd_pkg::SLOTS_DEFAULT,
   parameter int TILE_SIDE = ltcd_pkg::TILE_SIDE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   ltcd_req_if.sink                    req_if,
   ltcd_rsp_if.source                  rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ltcd_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   logic                    enabled;
   ltcd_pkg::tile_info_type tile;

   ltcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .enabled (enabled)
   );

   ltcd_tile_calc #(.TILE_SIDE(TILE_SIDE)) u_tile (
      .world_x (req_if.world_x),
      .world_z (req_if.world_z),
      .tile    (tile)
   );

   ltcd_engine #(.SLOTS(SLOTS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .enabled (enabled),
      .tile    (tile),
      .req     (req_if),
      .rsp     (rsp_if)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("item accepted while another is in flight");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == ltcd_pkg::ST_DISABLED)
      |-> (rsp_if.tile_x == 24'sd0 && rsp_if.tile_z == 24'sd0
           && rsp_if.pixel_index == 16'd0))
      else $error("disabled result carries tile fields");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status == ltcd_pkg::ST_DONE
                        || rsp_if.status == ltcd_pkg::ST_DROPPED))
      |-> (rsp_if.tile_x == 24'sd0 && rsp_if.tile_z == 24'sd0
           && rsp_if.pixel_index == 16'd0))
      else $error("slot item result carries tile fields");
`endif
endmodule
